FILE: hdl/pip_pkg.sv
// Shared types, constants and helpers of the point-in-polygon block.
package pip_pkg;

  localparam int CW     = 32;       // coordinate width, signed Q16.16
  localparam int W1     = CW + 1;   // exact difference of two coordinates
  localparam int PW     = 2 * CW;   // unsigned cross product
  localparam int SW     = PW + 1;   // sign-corrected cross product
  localparam int CLO_W  = 16;       // closeness register width
  localparam int IDX_W  = 2;        // configuration index width
  localparam int QDEPTH = 4;        // command queue depth
  localparam int QAW    = 2;        // command queue address width

  localparam logic [IDX_W-1:0] REG_QUERY_X   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_QUERY_Y   = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_CLOSENESS = IDX_W'(2);

  localparam logic [CLO_W-1:0] CLO_RESET = CLO_W'(66);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [W1-1:0] wide_t;

  typedef enum logic [1:0] {
    OP_EDGE,   // test one edge, fold into parity
    OP_CLOSE,  // test closing edge, then report parity
    OP_DEGEN   // report a polygon with fewer than three vertices
  } op_e;

  typedef struct packed {
    op_e    op;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } cmd_t;

  typedef struct packed {
    coord_t             qx;
    coord_t             qy;
    logic [CLO_W-1:0]   clo;
  } cfg_t;

  function automatic wide_t ext(coord_t v);
    return {v[CW-1], v};
  endfunction

  // |d| < c, written as two compares
  function automatic logic near(wide_t d, logic [CLO_W-1:0] c);
    wide_t cs;
    cs = wide_t'({{(W1-CLO_W){1'b0}}, c});
    return (d < cs) && (d > -cs);
  endfunction

endpackage

FILE: hdl/pip_ifs.sv
// Handshake channel interfaces: vertex input, result output, register writes.
interface pip_vertex_if;
  logic            valid;
  logic            ready;
  pip_pkg::coord_t vertex_x;
  pip_pkg::coord_t vertex_y;
  logic            last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

interface pip_result_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic degenerate;

  modport source (output valid, output inside_res, output degenerate, input ready);
  modport sink   (input valid, input inside_res, input degenerate, output ready);
endinterface

interface pip_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pip_pkg::IDX_W-1:0]      index;
  logic [pip_pkg::CW-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/pip_front.sv
// Front end: accepts vertices, tracks first/previous vertex and issues edge commands.
module pip_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  pip_vertex_if.sink    vtx_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output pip_pkg::cmd_t cmd_o
);

  logic            pend_q, pend_d;
  logic [1:0]      seen_q, seen_d;
  pip_pkg::coord_t first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic            accept;
  logic            gen_now;
  pip_pkg::cmd_t   cmd_now;
  pip_pkg::cmd_t   cmd_close;

  assign vtx_i.ready = !pend_q && cmd_ready_i;
  assign accept      = vtx_i.valid && vtx_i.ready;

  always_comb begin
    cmd_now.op = pip_pkg::OP_EDGE;
    cmd_now.sx = prev_x_q;
    cmd_now.sy = prev_y_q;
    cmd_now.ex = vtx_i.vertex_x;
    cmd_now.ey = vtx_i.vertex_y;
    gen_now    = 1'b1;
    if (seen_q == 2'd0) begin
      gen_now    = vtx_i.last_vertex;
      cmd_now.op = pip_pkg::OP_DEGEN;
    end else if (vtx_i.last_vertex && seen_q == 2'd1) begin
      cmd_now.op = pip_pkg::OP_DEGEN;
    end
  end

  // closing edge runs from the first vertex to the last one, now held as previous
  always_comb begin
    cmd_close.op = pip_pkg::OP_CLOSE;
    cmd_close.sx = first_x_q;
    cmd_close.sy = first_y_q;
    cmd_close.ex = prev_x_q;
    cmd_close.ey = prev_y_q;
  end

  assign cmd_valid_o = pend_q || (vtx_i.valid && gen_now && cmd_ready_i);
  assign cmd_o       = pend_q ? cmd_close : cmd_now;

  always_comb begin
    pend_d = pend_q;
    seen_d = seen_q;
    if (pend_q && cmd_ready_i) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      pend_d = vtx_i.last_vertex && seen_q[1];
      if (vtx_i.last_vertex) begin
        seen_d = 2'd0;
      end else if (seen_q != 2'd3) begin
        seen_d = seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      seen_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (seen_q == 2'd0) begin
        first_x_q <= vtx_i.vertex_x;
        first_y_q <= vtx_i.vertex_y;
      end
      prev_x_q <= vtx_i.vertex_x;
      prev_y_q <= vtx_i.vertex_y;
    end
  end

endmodule

FILE: hdl/pip_fifo.sv
// Short command queue between front end and edge tester.
module pip_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  pip_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output pip_pkg::cmd_t pop_data_o
);

  pip_pkg::cmd_t                mem_q [pip_pkg::QDEPTH];
  logic [pip_pkg::QAW-1:0]      wr_q, rd_q;
  logic [pip_pkg::QAW:0]        cnt_q;
  logic                         push, pop;

  assign push_ready_o = cnt_q != (pip_pkg::QAW+1)'(pip_pkg::QDEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: hdl/pip_back.sv
// Back end: sequenced ray-crossing test of one edge, parity and result register.
module pip_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pip_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  pip_pkg::cmd_t cmd_i,
  pip_result_if.source  res_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ORDER  = 4'd1;
  localparam logic [3:0] S_NUDGE  = 4'd2;
  localparam logic [3:0] S_CLASS  = 4'd3;
  localparam logic [3:0] S_ABS    = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_SIGN   = 4'd6;
  localparam logic [3:0] S_CMP    = 4'd7;
  localparam logic [3:0] S_DECIDE = 4'd8;

  logic [3:0]                  state_q, state_d;
  pip_pkg::cmd_t               cmd_q;
  pip_pkg::coord_t             sx_q, sy_q, ex_q, ey_q;
  logic                        nudge_q;
  pip_pkg::wide_t              py_q, run_s_q, run_p_q;
  logic [pip_pkg::CW-1:0]      rise_p_q, rise_s_q, mag_s_q, mag_p_q;
  logic                        lneg_q, rneg_q, dsign_q;
  logic [pip_pkg::PW-1:0]      lp_q, rp_q;
  logic signed [pip_pkg::SW-1:0] l_q, r_q;
  logic                        hit_q, hit_d;
  logic                        parity_q, parity_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_inside_q, out_inside_d;
  logic                        out_degen_q, out_degen_d;

  // order stage
  logic                        swap, near_y;
  // nudge stage
  pip_pkg::wide_t              py_n;
  // classify stage
  logic                        miss, cross_edge;
  pip_pkg::wide_t              run_s_c, run_p_c, rise_s_full;
  logic signed [pip_pkg::W1:0] rise_p_full;
  // magnitude stage
  logic                        inf_s, inf_p;
  pip_pkg::wide_t              abs_s, abs_p;
  // multiply stage
  logic [pip_pkg::PW-1:0]      lp_c, rp_c;
  // sign stage
  logic signed [pip_pkg::SW-1:0] l_c, r_c;
  logic                        out_free;

  assign cmd_ready_o = state_q == S_IDLE;
  assign out_free    = !out_valid_q || res_o.ready;

  assign res_o.valid      = out_valid_q;
  assign res_o.inside_res = out_inside_q;
  assign res_o.degenerate = out_degen_q;

  always_comb begin
    swap   = cmd_q.sy > cmd_q.ey;
    near_y = pip_pkg::near(pip_pkg::ext(cfg_i.qy) - pip_pkg::ext(cmd_q.sy), cfg_i.clo) ||
             pip_pkg::near(pip_pkg::ext(cfg_i.qy) - pip_pkg::ext(cmd_q.ey), cfg_i.clo);
  end

  assign py_n = pip_pkg::ext(cfg_i.qy) +
                pip_pkg::wide_t'({{(pip_pkg::W1-pip_pkg::CLO_W){1'b0}},
                                  (nudge_q ? cfg_i.clo : {pip_pkg::CLO_W{1'b0}})});

  always_comb begin
    miss = (py_q < pip_pkg::ext(sy_q)) || (py_q > pip_pkg::ext(ey_q)) ||
           ((cfg_i.qx >= sx_q) && (cfg_i.qx >= ex_q));
    cross_edge  = (cfg_i.qx < sx_q) && (cfg_i.qx < ex_q);
    run_s_c     = pip_pkg::ext(ex_q) - pip_pkg::ext(sx_q);
    run_p_c     = pip_pkg::ext(cfg_i.qx) - pip_pkg::ext(sx_q);
    rise_s_full = pip_pkg::ext(ey_q) - pip_pkg::ext(sy_q);
    rise_p_full = {py_q[pip_pkg::W1-1], py_q} - {{2{sy_q[pip_pkg::CW-1]}}, sy_q};
  end

  always_comb begin
    inf_s = (run_s_q == '0) || pip_pkg::near(run_s_q, cfg_i.clo);
    inf_p = (run_p_q == '0) || pip_pkg::near(run_p_q, cfg_i.clo);
    abs_s = run_s_q[pip_pkg::W1-1] ? -run_s_q : run_s_q;
    abs_p = run_p_q[pip_pkg::W1-1] ? -run_p_q : run_p_q;
  end

  assign lp_c = rise_p_q * mag_s_q;
  assign rp_c = rise_s_q * mag_p_q;

  assign l_c = lneg_q ? -$signed({1'b0, lp_q}) : $signed({1'b0, lp_q});
  assign r_c = rneg_q ? -$signed({1'b0, rp_q}) : $signed({1'b0, rp_q});

  always_comb begin
    state_d      = state_q;
    hit_d        = hit_q;
    parity_d     = parity_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_inside_d = out_inside_q;
    out_degen_d  = out_degen_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.op == pip_pkg::OP_DEGEN) ? S_DECIDE : S_ORDER;
        end
      end
      S_ORDER: state_d = S_NUDGE;
      S_NUDGE: state_d = S_CLASS;
      S_CLASS: begin
        if (miss) begin
          hit_d   = 1'b0;
          state_d = S_DECIDE;
        end else if (cross_edge) begin
          hit_d   = 1'b1;
          state_d = S_DECIDE;
        end else begin
          state_d = S_ABS;
        end
      end
      S_ABS: begin
        if (inf_p) begin
          hit_d   = 1'b1;
          state_d = S_DECIDE;
        end else if (inf_s) begin
          hit_d   = 1'b0;
          state_d = S_DECIDE;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_SIGN;
      S_SIGN: state_d = S_CMP;
      S_CMP: begin
        hit_d   = dsign_q ? (l_q <= r_q) : (l_q >= r_q);
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (cmd_q.op)
          pip_pkg::OP_EDGE: begin
            parity_d = parity_q ^ hit_q;
            state_d  = S_IDLE;
          end
          pip_pkg::OP_CLOSE: begin
            if (out_free) begin
              out_valid_d  = 1'b1;
              out_inside_d = parity_q ^ hit_q;
              out_degen_d  = 1'b0;
              parity_d     = 1'b0;
              state_d      = S_IDLE;
            end
          end
          pip_pkg::OP_DEGEN: begin
            if (out_free) begin
              out_valid_d  = 1'b1;
              out_inside_d = 1'b0;
              out_degen_d  = 1'b1;
              parity_d     = 1'b0;
              state_d      = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      parity_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      parity_q    <= parity_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q        <= hit_d;
    out_inside_q <= out_inside_d;
    out_degen_q  <= out_degen_d;
    if (state_q == S_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    if (state_q == S_ORDER) begin
      sx_q    <= swap ? cmd_q.ex : cmd_q.sx;
      sy_q    <= swap ? cmd_q.ey : cmd_q.sy;
      ex_q    <= swap ? cmd_q.sx : cmd_q.ex;
      ey_q    <= swap ? cmd_q.sy : cmd_q.ey;
      nudge_q <= near_y;
    end
    if (state_q == S_NUDGE) begin
      py_q <= py_n;
    end
    if (state_q == S_CLASS) begin
      run_s_q  <= run_s_c;
      run_p_q  <= run_p_c;
      rise_s_q <= rise_s_full[pip_pkg::CW-1:0];
      rise_p_q <= rise_p_full[pip_pkg::CW-1:0];
    end
    if (state_q == S_ABS) begin
      mag_s_q <= abs_s[pip_pkg::CW-1:0];
      mag_p_q <= abs_p[pip_pkg::CW-1:0];
      lneg_q  <= run_s_q[pip_pkg::W1-1] && (rise_p_q != '0);
      rneg_q  <= run_p_q[pip_pkg::W1-1] && (rise_s_q != '0);
      dsign_q <= run_s_q[pip_pkg::W1-1] != run_p_q[pip_pkg::W1-1];
    end
    if (state_q == S_MUL) begin
      lp_q <= lp_c;
      rp_q <= rp_c;
    end
    if (state_q == S_SIGN) begin
      l_q <= l_c;
      r_q <= r_c;
    end
  end

endmodule

FILE: hdl/point_in_polygon_even_odd.sv
// Even-odd point-in-polygon tester: top level with register file and front/back split.
//
// Streams polygon vertices (signed Q16.16) on vertex_i, one per transfer, the
// last one flagged, and returns one transfer on result_o per polygon: the
// crossing parity of a rightward ray from (query_x, query_y), or degenerate
// when fewer than three vertices came. The front end takes a vertex whenever
// the four-entry command queue has room; the final vertex of a polygon of three
// or more queues its own edge test and the closing edge test, and holds the input
// until the closing edge is queued. The back end runs each edge test through a
// shared sequencer: order, nudge, classify when the bounds decide it, then
// magnitude when a near-vertical run does, then multiply, sign and compare
// when the exact cross multiplication (two 32x32 multiplies) is needed; that
// sequencer sets the sustained rate. Registers: 0 query_x, 1 query_y, 2 closeness
// (low 16 bits of the data); writes to index 3 are taken and dropped. Write
// registers only while no polygon is in flight.
module point_in_polygon_even_odd (
  input  logic          clk_i,
  input  logic          rst_ni,
  pip_vertex_if.sink    vertex_i,
  pip_result_if.source  result_o,
  pip_cfg_if.sink       cfg_i
);

  pip_pkg::cfg_t cfg_q;
  logic          cmd_valid, cmd_ready;
  pip_pkg::cmd_t cmd;
  logic          q_valid, q_ready;
  pip_pkg::cmd_t q_cmd;

  // register writes never stall
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.qx  <= '0;
      cfg_q.qy  <= '0;
      cfg_q.clo <= pip_pkg::CLO_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pip_pkg::REG_QUERY_X:   cfg_q.qx  <= cfg_i.data;
        pip_pkg::REG_QUERY_Y:   cfg_q.qy  <= cfg_i.data;
        pip_pkg::REG_CLOSENESS: cfg_q.clo <= cfg_i.data[pip_pkg::CLO_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // front end: vertex bookkeeping, up to two commands per vertex
  pip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vtx_i       (vertex_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // decouple front and back so each can stall on its own
  pip_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_data_i  (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  // back end: edge test, parity, result register
  pip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_o       (result_o)
  );

endmodule

FILE: sim/point_in_polygon_even_odd_test.sv
// Self-checking testbench of the even-odd point-in-polygon block.
`timescale 1ns / 100ps

module point_in_polygon_even_odd_test;

  // Write index 3: the block takes the transfer and drops the data.
  localparam logic [pip_pkg::IDX_W-1:0] REG_UNUSED = (pip_pkg::IDX_W)'(3);

  localparam pip_pkg::coord_t ONE       = 32'sh0001_0000;  // 1.0 in Q16.16
  localparam pip_pkg::coord_t COORD_MIN = 32'sh8000_0000;
  localparam pip_pkg::coord_t COORD_MAX = 32'sh7FFF_FFFF;

  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 120;   // vertices per phase, roughly
  localparam int unsigned SETTLE_CYCLES = 40;    // covers two full-length edge tests and slack
  localparam int unsigned LONG_HOLD     = 400;   // long result back-pressure
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned TIMEOUT_NS    = 1_000_000;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } verdict_t;

  typedef enum int unsigned {
    SINK_OPEN,      // always ready
    SINK_HALF,      // ready about half the time
    SINK_SPARSE,    // ready about one cycle in four
    SINK_PERIODIC   // drop ready one cycle in five
  } sink_mode_e;

  // Keeps its own copy of the registers and the polygon state, and the verdicts
  // still owed by the block, oldest first.
  class polygon_scoreboard;
    pip_pkg::coord_t           qx;
    pip_pkg::coord_t           qy;
    logic [pip_pkg::CLO_W-1:0] clo;
    pip_pkg::coord_t           first_x;
    pip_pkg::coord_t           first_y;
    pip_pkg::coord_t           prev_x;
    pip_pkg::coord_t           prev_y;
    int unsigned               seen;
    bit                        parity;
    verdict_t                  verdicts_owed[$];
    int unsigned               failures;

    function new();
      qx       = '0;
      qy       = '0;
      clo      = pip_pkg::CLO_RESET;
      first_x  = '0;
      first_y  = '0;
      prev_x   = '0;
      prev_y   = '0;
      seen     = 0;
      parity   = 1'b0;
      failures = 0;
    endfunction

    function void set_reg(logic [pip_pkg::IDX_W-1:0] idx, logic [pip_pkg::CW-1:0] value);
      case (idx)
        pip_pkg::REG_QUERY_X:   qx  = pip_pkg::coord_t'(value);
        pip_pkg::REG_QUERY_Y:   qy  = pip_pkg::coord_t'(value);
        pip_pkg::REG_CLOSENESS: clo = value[pip_pkg::CLO_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_close(logic signed [39:0] a, logic signed [39:0] b);
      logic signed [39:0] d;
      d = a - b;
      if (d < 0) d = -d;
      return d < $signed({24'b0, clo});
    endfunction

    // Rightward ray from the query point against one edge, exact at 40 and 80 bits.
    function bit ray_crosses(pip_pkg::coord_t sx, pip_pkg::coord_t sy,
                             pip_pkg::coord_t ex, pip_pkg::coord_t ey);
      logic signed [39:0] ax, ay, bx, by, px, py, t;
      logic signed [39:0] lo_x, hi_x, run_s, run_p, rise_s, rise_p;
      logic signed [79:0] lhs, rhs;
      ax = sx;
      ay = sy;
      bx = ex;
      by = ey;
      px = qx;
      py = qy;
      // order by y; on equal y the earlier vertex stays at the start
      if (ay > by) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      // nudge the ray up when it grazes an endpoint
      if (is_close(py, ay) || is_close(py, by)) py = py + $signed({24'b0, clo});
      if (py < ay || py > by) return 1'b0;
      hi_x = (ax > bx) ? ax : bx;
      lo_x = (ax < bx) ? ax : bx;
      if (px >= hi_x) return 1'b0;
      if (px < lo_x) return 1'b1;
      run_s = bx - ax;
      run_p = px - ax;
      // a run of zero or below tolerance is an infinite slope
      if (run_p == 0 || is_close(px, ax)) return 1'b1;
      if (run_s == 0 || is_close(bx, ax)) return 1'b0;
      rise_p = py - ay;
      rise_s = by - ay;
      lhs = rise_p * run_s;
      rhs = rise_s * run_p;
      if ((run_s < 0) == (run_p < 0)) return lhs >= rhs;
      return lhs <= rhs;
    endfunction

    function void note_vertex(pip_pkg::coord_t x, pip_pkg::coord_t y, logic last);
      verdict_t v;
      if (seen == 0) begin
        first_x = x;
        first_y = y;
      end else if (ray_crosses(prev_x, prev_y, x, y)) begin
        parity = ~parity;
      end
      prev_x = x;
      prev_y = y;
      if (seen < 3) seen++;
      if (last) begin
        if (seen < 3) begin
          v.inside_res = 1'b0;
          v.degenerate = 1'b1;
        end else begin
          // closing edge runs from the first vertex to this one
          v.inside_res = parity ^ ray_crosses(first_x, first_y, x, y);
          v.degenerate = 1'b0;
        end
        verdicts_owed.push_back(v);
        seen   = 0;
        parity = 1'b0;
      end
    endfunction

    function void check_result(logic inside_res, logic degenerate);
      verdict_t want;
      if (verdicts_owed.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: inside_res=%0b degenerate=%0b",
                   inside_res, degenerate);
        return;
      end
      want = verdicts_owed.pop_front();
      if (inside_res !== want.inside_res || degenerate !== want.degenerate) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display({"mismatch: expected inside_res=%0b degenerate=%0b, ",
                    "got inside_res=%0b degenerate=%0b"},
                   want.inside_res, want.degenerate, inside_res, degenerate);
      end
    endfunction

    function int unsigned outstanding();
      return verdicts_owed.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pip_vertex_if vtx_if ();
  pip_result_if res_if ();
  pip_cfg_if    cfg_if ();

  point_in_polygon_even_odd dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vertex_i (vtx_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  polygon_scoreboard sb = new();

  int unsigned burst_left   = 0;
  bit          hold_request = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sample both channels at the falling edge, where everything is settled: a
  // transfer seen here completes at the next rising edge. Note the vertex first
  // so a same-cycle result always finds its verdict.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (vtx_if.valid && vtx_if.ready)
        sb.note_vertex(vtx_if.vertex_x, vtx_if.vertex_y, vtx_if.last_vertex);
      if (res_if.valid && res_if.ready)
        sb.check_result(res_if.inside_res, res_if.degenerate);
    end
  end

  // Result sink: switch between randomly chosen stall patterns, and hold ready
  // low for a long stretch whenever the stimulus asks for it.
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned tick;
    logic        ready_next;
    res_if.ready <= 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 120);
      end
      mode_left--;
      tick++;
      if (hold_left != 0) begin
        ready_next = 1'b0;
        hold_left--;
      end else begin
        case (mode)
          SINK_OPEN:   ready_next = 1'b1;
          SINK_HALF:   ready_next = 1'($urandom_range(0, 1));
          SINK_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
          default:     ready_next = (tick % 5 != 0);
        endcase
      end
      res_if.ready <= ready_next;
    end
  end

  // Offer one vertex and return at the rising edge of its transfer. Start a
  // new burst, after a random gap, when the current one runs out.
  task automatic send_vertex(input pip_pkg::coord_t x, input pip_pkg::coord_t y,
                             input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        vtx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    vtx_if.valid       <= 1'b1;
    vtx_if.vertex_x    <= x;
    vtx_if.vertex_y    <= y;
    vtx_if.last_vertex <= last;
    do @(negedge clk_i); while (!vtx_if.ready);
    @(posedge clk_i);
  endtask

  // Write one register; leaves valid high so back-to-back writes need no gap.
  task automatic write_reg(input logic [pip_pkg::IDX_W-1:0] idx,
                           input logic [pip_pkg::CW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(negedge clk_i); while (!cfg_if.ready);
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  // Drop vertex valid, wait out every owed verdict, then let the back end drain.
  task automatic drain;
    vtx_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly coordinates close to the query point, some within a few tolerances
  // of it, some anywhere, some repeating the previous vertex (flat or vertical
  // edges).
  function automatic pip_pkg::coord_t pick_coord(pip_pkg::coord_t center,
                                                 pip_pkg::coord_t last_val,
                                                 logic [pip_pkg::CLO_W-1:0] tol);
    int unsigned sel;
    int          span;
    int          off;
    sel  = $urandom_range(0, 99);
    span = int'(tol) * 3 + 8;
    if (sel < 35) begin
      off = int'($urandom_range(0, 2 * span)) - span;
      return center + pip_pkg::coord_t'(off);
    end
    if (sel < 60) return center + pip_pkg::coord_t'($signed($urandom) >>> 11);
    if (sel < 82) return pip_pkg::coord_t'($urandom);
    if (sel < 91) return center;
    return last_val;
  endfunction

  // Mostly real polygons; a few too short to count.
  function automatic int unsigned pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8)  return 1;
    if (sel < 15) return 2;
    if (sel < 20) return $urandom_range(8, 12);
    return $urandom_range(3, 7);
  endfunction

  task automatic send_polygon(input int unsigned n);
    pip_pkg::coord_t x, y, px, py;
    px = sb.qx;
    py = sb.qy;
    for (int unsigned i = 0; i < n; i++) begin
      x = pick_coord(sb.qx, px, sb.clo);
      y = pick_coord(sb.qy, py, sb.clo);
      send_vertex(x, y, i == n - 1);
      px = x;
      py = y;
    end
  endtask

  // Hand-picked polygons under the reset settings: query at the origin,
  // tolerance 66.
  task automatic send_directed;
    // triangle around the origin
    send_vertex(-ONE, -ONE, 1'b0);
    send_vertex( ONE, -ONE, 1'b0);
    send_vertex('0,    ONE, 1'b1);
    // triangle wholly to the right: ray crosses twice
    send_vertex(2 * ONE, -ONE, 1'b0);
    send_vertex(4 * ONE, -ONE, 1'b0);
    send_vertex(3 * ONE,  ONE, 1'b1);
    // too few vertices: one, then two at the coordinate extremes
    send_vertex('0, '0, 1'b1);
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b1);
    // square spanning the whole coordinate range
    send_vertex(COORD_MIN, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MIN, 1'b0);
    send_vertex(COORD_MAX, COORD_MAX, 1'b0);
    send_vertex(COORD_MIN, COORD_MAX, 1'b1);
    // vertex exactly on the ray: nudge the ray up
    send_vertex( ONE, '0,   1'b0);
    send_vertex(-ONE, -ONE, 1'b0);
    send_vertex(-ONE,  ONE, 1'b1);
    // vertex just within tolerance of the ray
    send_vertex(2 * ONE, 32'sd33, 1'b0);
    send_vertex(3 * ONE, -ONE,    1'b0);
    send_vertex(3 * ONE,  ONE,    1'b1);
    // exactly vertical edge on the query x
    send_vertex('0, -ONE, 1'b0);
    send_vertex('0,  ONE, 1'b0);
    send_vertex(2 * ONE, '0, 1'b1);
    // near-vertical edge straddling the query x, run below tolerance
    send_vertex( 32'sd5, -ONE, 1'b0);
    send_vertex(-32'sd5,  ONE, 1'b0);
    send_vertex(2 * ONE,  ONE, 1'b1);
  endtask

  initial begin : stimulus
    pip_pkg::coord_t           qx_next;
    pip_pkg::coord_t           qy_next;
    logic [pip_pkg::CLO_W-1:0] clo_next;
    int unsigned               sent;
    int unsigned               n;
    rst_ni             <= 1'b0;
    vtx_if.valid       <= 1'b0;
    vtx_if.vertex_x    <= '0;
    vtx_if.vertex_y    <= '0;
    vtx_if.last_vertex <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= '0;
    cfg_if.data        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_directed();

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      // Registers change only with nothing in flight.
      drain();
      case (phase)
        0: begin
          qx_next  = '0;
          qy_next  = '0;
          clo_next = pip_pkg::CLO_RESET;
        end
        1: begin qx_next = COORD_MIN; qy_next = COORD_MAX; clo_next = '0;        end
        2: begin qx_next = COORD_MAX; qy_next = COORD_MIN; clo_next = '1;        end
        3: begin qx_next = $urandom;  qy_next = $urandom;  clo_next = 16'd1;     end
        5: begin
          qx_next  = 32'sh0001_8000;
          qy_next  = -32'sh0002_4000;
          clo_next = pip_pkg::CLO_RESET;
        end
        6: begin qx_next = $urandom;  qy_next = $urandom;  clo_next = '1;        end
        7: begin qx_next = $urandom;  qy_next = $urandom;  clo_next = '0;        end
        default: begin
          qx_next  = $urandom;
          qy_next  = $urandom;
          clo_next = pip_pkg::CLO_W'($urandom_range(0, 65535));
        end
      endcase
      write_reg(pip_pkg::REG_QUERY_X, qx_next);
      write_reg(pip_pkg::REG_QUERY_Y, qy_next);
      // random upper bits must be dropped by the closeness register
      write_reg(pip_pkg::REG_CLOSENESS, {16'($urandom), clo_next});
      if (phase == 0) write_reg(REG_UNUSED, $urandom);
      cfg_if.valid <= 1'b0;

      // Hold the results back long enough to fill the block and stall its input.
      if (phase == 4) hold_request = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n = pick_length();
        send_polygon(n);
        sent += n;
      end
    end

    drain();
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("point_in_polygon_even_odd_test: PASS");
    end else begin
      $display("point_in_polygon_even_odd_test: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("point_in_polygon_even_odd_test: FAIL");
    $finish;
  end

endmodule

FILE: point_in_polygon_even_odd.f
hdl/pip_pkg.sv
hdl/pip_ifs.sv
hdl/pip_front.sv
hdl/pip_fifo.sv
hdl/pip_back.sv
hdl/point_in_polygon_even_odd.sv
sim/point_in_polygon_even_odd_test.sv
